### sv/kmh_pkg.sv
// Package for the keyword match highlighter.
// Holds sizes, operation codes, tag characters, the state type and the dictionary write type.
// Depends on nothing; every other file of the block uses it by scoped names.
package kmh_pkg;

   // Dictionary and window sizes.
   localparam int MAX_WORDS = 64;
   localparam int MAX_LEN   = 8;
   localparam int SLOT_W    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int POS_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int FILL_W    = $clog2(MAX_LEN + 1);
   localparam int CNT_W     = $clog2(MAX_WORDS + 1);
   localparam int ROW_W     = MAX_LEN * 8;

   // Fixed field widths.
   localparam int OP_W    = 2;
   localparam int WSLOT_W = 6;
   localparam int CPOS_W  = 3;
   localparam int WLEN_W  = 4;
   localparam int WORDS_W = 7;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_KEY_BYTE = 2'd0;
   localparam logic [OP_W-1:0] OP_KEY_LEN  = 2'd1;
   localparam logic [OP_W-1:0] OP_TEXT     = 2'd2;

   // Tag characters.
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRE,
      ST_MATCH,
      ST_FLUSH,
      ST_CLOSE
   } state_type;

   // One dictionary write.
   typedef struct packed {
      logic               byte_en;
      logic               len_en;
      logic [SLOT_W-1:0]  slot;
      logic [POS_W-1:0]   pos;
      logic [WLEN_W-1:0]  len;
      logic [7:0]         data;
   } dict_wr_type;

   // Character of an opening or closing tag at a given index.
   function automatic logic [7:0] tag_char(input logic closing, input logic [1:0] idx);
      logic [7:0] c;
      c = CH_GT;
      if (closing) begin
         unique case (idx)
            2'd0: c = CH_LT;
            2'd1: c = CH_SLASH;
            2'd2: c = CH_B;
            default: c = CH_GT;
         endcase
      end else begin
         unique case (idx)
            2'd0: c = CH_LT;
            2'd1: c = CH_B;
            default: c = CH_GT;
         endcase
      end
      return c;
   endfunction

endpackage

### sv/kmh_dict.sv
// Keyword dictionary: one row of keyword bytes and one length per entry.
// Uses kmh_pkg for sizes and the write command type. Read data is registered.
module kmh_dict (
   input  logic                       clock,
   input  logic                       reset,
   input  kmh_pkg::dict_wr_type       wr,
   input  logic [kmh_pkg::SLOT_W-1:0] rd_addr,
   output logic [kmh_pkg::ROW_W-1:0]  rd_row,
   output logic [kmh_pkg::WLEN_W-1:0] rd_len
);

   logic [kmh_pkg::ROW_W-1:0]     row_mem [kmh_pkg::MAX_WORDS];
   logic [kmh_pkg::WLEN_W-1:0]    len_mem [kmh_pkg::MAX_WORDS];
   logic [kmh_pkg::MAX_WORDS-1:0] len_vld_ff;
   logic [kmh_pkg::ROW_W-1:0]     rd_row_ff;
   logic [kmh_pkg::WLEN_W-1:0]    rd_len_ff;
   logic                          rd_vld_ff;

   // Keyword bytes: one byte lane written per item.
   always_ff @(posedge clock) begin
      if (wr.byte_en) begin
         row_mem[wr.slot][wr.pos*8 +: 8] <= wr.data;
      end
      rd_row_ff <= row_mem[rd_addr];
   end

   // Keyword lengths; an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (wr.len_en) begin
         len_mem[wr.slot] <= wr.len;
      end
      rd_len_ff <= len_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (wr.len_en) begin
            len_vld_ff[wr.slot] <= 1'b1;
         end
         rd_vld_ff <= len_vld_ff[rd_addr] | (wr.len_en && wr.slot == rd_addr);
      end
   end

   assign rd_row = rd_row_ff;
   assign rd_len = rd_vld_ff ? rd_len_ff : '0;

endmodule

### sv/keyword_match_highlighter.sv
// Top level of the keyword match highlighter: sequencer, text window and output register.
// Uses kmh_pkg and instantiates kmh_dict.
//
//  channel | direction | handshake               | contents
//  req     | in        | req_tvalid / req_tready | keyword writes and text bytes
//  rsp     | out       | rsp_tvalid / rsp_tready | text and tag characters
//  csr     | in        | csr_valid / csr_ready   | words_in_use
//
// Dictionary writes complete as they are accepted. A text item is accepted, is compared with
// each active dictionary entry in turn through the registered read and a final check, and
// may emit characters; the single-entry compare over the dictionary port sets the pace.
// Reset is synchronous and clears the window, the run flag and the length valid bits.
// A stalled rsp holds the sequencer; req is not ready until the item is finished.
module keyword_match_highlighter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // word_slot, char_position, word_length, data_byte, pad
   input  logic        req_tlast,   // text_last
   input  logic [1:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast,   // run_last
   output logic        rsp_tuser,   // text_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // words_in_use, pad
);

   localparam int L = kmh_pkg::MAX_LEN;

   kmh_pkg::state_type state_ff, state_in;

   logic [7:0]                   win_ff [L];
   logic [L-1:0]                 mark_ff;
   logic [kmh_pkg::FILL_W-1:0]   fill_ff;
   logic                         run_open_ff;
   logic [7:0]                   byte_ff;
   logic                         last_ff;
   logic [2:0]                   ph_ff;
   logic [kmh_pkg::CNT_W-1:0]    cnt_ff;
   logic                         pend_ff;
   logic [kmh_pkg::WORDS_W-1:0]  words_ff;
   logic                         rsp_tvalid_ff;
   logic [7:0]                   rsp_tdata_ff;
   logic                         rsp_tlast_ff;
   logic                         rsp_tuser_ff;

   // Input fields.
   logic [kmh_pkg::OP_W-1:0]    op;
   logic [kmh_pkg::WSLOT_W-1:0] f_slot;
   logic [kmh_pkg::CPOS_W-1:0]  f_pos;
   logic [kmh_pkg::WLEN_W-1:0]  f_len;
   logic [7:0]                  f_byte;
   logic                        acc;

   assign op     = req_tuser;
   assign f_slot = req_tdata[5:0];
   assign f_pos  = req_tdata[8:6];
   assign f_len  = req_tdata[12:9];
   assign f_byte = req_tdata[20:13];
   assign acc    = req_tvalid && req_tready;

   // Dictionary.
   kmh_pkg::dict_wr_type         dwr;
   logic [kmh_pkg::ROW_W-1:0]    rd_row;
   logic [kmh_pkg::WLEN_W-1:0]   rd_len;

   always_comb begin
      dwr.byte_en = acc && op == kmh_pkg::OP_KEY_BYTE
                    && int'(f_slot) < kmh_pkg::MAX_WORDS && int'(f_pos) < kmh_pkg::MAX_LEN;
      dwr.len_en  = acc && op == kmh_pkg::OP_KEY_LEN && int'(f_slot) < kmh_pkg::MAX_WORDS;
      dwr.slot    = kmh_pkg::SLOT_W'(f_slot);
      dwr.pos     = kmh_pkg::POS_W'(f_pos);
      dwr.len     = f_len;
      dwr.data    = f_byte;
   end

   kmh_dict u_dict (
      .clock   (clock),
      .reset   (reset),
      .wr      (dwr),
      .rd_addr (cnt_ff[kmh_pkg::SLOT_W-1:0]),
      .rd_row  (rd_row),
      .rd_len  (rd_len)
   );

   // Number of entries in use, limited to the dictionary size.
   logic [kmh_pkg::CNT_W-1:0] n_words;
   logic                      issue;
   assign n_words = (int'(words_ff) > kmh_pkg::MAX_WORDS) ? kmh_pkg::CNT_W'(kmh_pkg::MAX_WORDS)
                                                       : kmh_pkg::CNT_W'(words_ff);
   assign issue = (state_ff == kmh_pkg::ST_MATCH) && (cnt_ff < n_words);

   // Shared compare unit: the registered entry against the window tail.
   logic [L-1:0] covered;
   logic [L-1:0] eq;
   logic         len_ok;
   logic         hit;
   logic [kmh_pkg::FILL_W-1:0] base;
   logic [kmh_pkg::POS_W-1:0]  kidx [L];

   always_comb begin
      len_ok = rd_len != '0 && int'(rd_len) <= L && int'(rd_len) <= int'(fill_ff);
      base   = fill_ff - kmh_pkg::FILL_W'(rd_len);
      for (int j = 0; j < L; j++) begin
         covered[j] = j >= int'(base) && j < int'(fill_ff);
         kidx[j]    = kmh_pkg::POS_W'(kmh_pkg::FILL_W'(j) - base);
         eq[j]      = win_ff[j] == rd_row[kidx[j]*8 +: 8];
      end
      hit = pend_ff && len_ok && (&(~covered | eq));
   end

   // Emission controls.
   logic       out_free;
   logic       emit;
   logic [7:0] emit_char;
   logic       emit_last;
   logic       emit_byte;
   logic       close_done;
   logic       m0;
   logic       need_tag;
   logic [2:0] tag_len;

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign m0       = mark_ff[0];
   assign need_tag = m0 != run_open_ff;
   assign tag_len  = m0 ? 3'd3 : 3'd4;

   always_comb begin
      emit       = 1'b0;
      emit_char  = win_ff[0];
      emit_last  = 1'b0;
      emit_byte  = 1'b0;
      close_done = 1'b0;
      unique case (state_ff)
         kmh_pkg::ST_PRE, kmh_pkg::ST_FLUSH: begin
            emit = out_free;
            if (need_tag && ph_ff < tag_len) begin
               emit_char = kmh_pkg::tag_char(!m0, ph_ff[1:0]);
            end else begin
               emit_byte = out_free;
               if (state_ff == kmh_pkg::ST_PRE) begin
                  emit_last = !last_ff;
               end else begin
                  emit_last = fill_ff == kmh_pkg::FILL_W'(1) && !m0;
               end
            end
         end
         kmh_pkg::ST_CLOSE: begin
            emit       = out_free;
            emit_char  = kmh_pkg::tag_char(1'b1, ph_ff[1:0]);
            emit_last  = ph_ff == 3'd3;
            close_done = out_free && ph_ff == 3'd3;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kmh_pkg::ST_IDLE: begin
            if (acc && op == kmh_pkg::OP_TEXT) begin
               state_in = (int'(fill_ff) >= L) ? kmh_pkg::ST_PRE : kmh_pkg::ST_MATCH;
            end
         end
         kmh_pkg::ST_PRE: begin
            if (emit_byte) begin
               state_in = kmh_pkg::ST_MATCH;
            end
         end
         kmh_pkg::ST_MATCH: begin
            if (!issue && !pend_ff) begin
               state_in = last_ff ? kmh_pkg::ST_FLUSH : kmh_pkg::ST_IDLE;
            end
         end
         kmh_pkg::ST_FLUSH: begin
            if (emit_byte && fill_ff == kmh_pkg::FILL_W'(1)) begin
               state_in = m0 ? kmh_pkg::ST_CLOSE : kmh_pkg::ST_IDLE;
            end
         end
         kmh_pkg::ST_CLOSE: begin
            if (close_done) begin
               state_in = kmh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kmh_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_tready = state_ff == kmh_pkg::ST_IDLE;
   assign csr_ready  = 1'b1;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kmh_pkg::ST_IDLE;
         mark_ff       <= '0;
         fill_ff       <= '0;
         run_open_ff   <= 1'b0;
         ph_ff         <= '0;
         cnt_ff        <= '0;
         pend_ff       <= 1'b0;
         words_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            words_ff <= csr_data[kmh_pkg::WORDS_W-1:0];
         end

         // Output register.
         if (emit) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end

         // Text byte enters a window that has room.
         if (acc && op == kmh_pkg::OP_TEXT && int'(fill_ff) < L) begin
            mark_ff[fill_ff[kmh_pkg::POS_W-1:0]] <= 1'b0;
            fill_ff <= fill_ff + kmh_pkg::FILL_W'(1);
         end

         // Dictionary scan.
         if (acc && op == kmh_pkg::OP_TEXT) begin
            cnt_ff  <= '0;
            pend_ff <= 1'b0;
         end else if (state_ff == kmh_pkg::ST_MATCH) begin
            pend_ff <= issue;
            if (issue) begin
               cnt_ff <= cnt_ff + kmh_pkg::CNT_W'(1);
            end
            if (hit) begin
               mark_ff <= mark_ff | covered;
            end
         end

         // Tag phase and window shift on emission.
         if (emit) begin
            if (emit_byte) begin
               ph_ff       <= '0;
               run_open_ff <= m0;
               mark_ff     <= {1'b0, mark_ff[L-1:1]};
               if (state_ff == kmh_pkg::ST_FLUSH) begin
                  fill_ff <= fill_ff - kmh_pkg::FILL_W'(1);
               end
            end else if (close_done) begin
               ph_ff       <= '0;
               run_open_ff <= 1'b0;
            end else begin
               ph_ff <= ph_ff + 3'd1;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (acc && op == kmh_pkg::OP_TEXT) begin
         byte_ff <= f_byte;
         last_ff <= req_tlast;
         if (int'(fill_ff) < L) begin
            win_ff[fill_ff[kmh_pkg::POS_W-1:0]] <= f_byte;
         end
      end
      if (emit_byte) begin
         for (int i = 0; i < L - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         if (state_ff == kmh_pkg::ST_PRE) begin
            win_ff[L-1] <= byte_ff;
         end
      end
      if (emit) begin
         rsp_tdata_ff <= emit_char;
         rsp_tlast_ff <= emit_last;
         rsp_tuser_ff <= emit_last && last_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule
